// File: rtl/oeg_pkg.sv
// ----------------------------------------------------------------------------
// oeg_pkg
// Shared widths, constants and word types of the orientation error gradient.
// ----------------------------------------------------------------------------
`default_nettype none

package oeg_pkg;

   // external field widths
   localparam int IN_W       = 16;
   localparam int OUT_W      = 24;
   localparam int FRAC_SHIFT = 28;

   // internal widths, sized to the value ranges of each stage
   localparam int QP_W  = 32;                  // q*q and q*r products, Q28
   localparam int FC_W  = 34;                  // objective coefficients, Q28
   localparam int JT_W  = 35;                  // Jacobian entries, Q28
   localparam int FP_W  = FC_W + IN_W;         // coefficient times reference, Q42
   localparam int F_W   = 52;                  // objective sum, Q42
   localparam int E_W   = F_W - FRAC_SHIFT;    // rounded error, Q14
   localparam int GP_W  = JT_W + E_W;          // Jacobian times error, Q42
   localparam int ACC_W = GP_W + 2;            // gradient sum, Q42
   localparam int RND_W = ACC_W - FRAC_SHIFT;  // rounded gradient, Q14

   // register stages from an accepted word to its result
   localparam int LATENCY = 6;

   // 1.0 in Q28
   localparam logic signed [JT_W-1:0] ONE_Q28 = JT_W'(1) << FRAC_SHIFT;

   typedef logic [2:0][IN_W-1:0] vec3_type;

   typedef struct packed {
      logic signed [IN_W-1:0] quat_w;
      logic signed [IN_W-1:0] quat_x;
      logic signed [IN_W-1:0] quat_y;
      logic signed [IN_W-1:0] quat_z;
      logic signed [IN_W-1:0] ref_x;
      logic signed [IN_W-1:0] ref_y;
      logic signed [IN_W-1:0] ref_z;
      logic signed [IN_W-1:0] meas_x;
      logic signed [IN_W-1:0] meas_y;
      logic signed [IN_W-1:0] meas_z;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] grad_w;
      logic signed [OUT_W-1:0] grad_x;
      logic signed [OUT_W-1:0] grad_y;
      logic signed [OUT_W-1:0] grad_z;
   } rsp_type;

   // stage 1: raw products; qr[i][k] = q_i * r_k with i over w,x,y,z
   typedef struct packed {
      logic [QP_W-1:0] xx;
      logic [QP_W-1:0] yy;
      logic [QP_W-1:0] zz;
      logic [QP_W-1:0] xy;
      logic [QP_W-1:0] xz;
      logic [QP_W-1:0] yz;
      logic [QP_W-1:0] wx;
      logic [QP_W-1:0] wy;
      logic [QP_W-1:0] wz;
      logic [3:0][2:0][QP_W-1:0] qr;
      vec3_type r;
      vec3_type m;
   } prod_type;

   // stage 2: fc[j][k] multiplies r_k in f_j; jt[i][j] is the transposed Jacobian
   typedef struct packed {
      logic [2:0][2:0][FC_W-1:0] fc;
      logic [3:0][2:0][JT_W-1:0] jt;
      vec3_type r;
      vec3_type m;
   } coef_type;

   // stage 4: rounded error and the Jacobian that goes with it
   typedef struct packed {
      logic [2:0][E_W-1:0] e;
      logic [3:0][2:0][JT_W-1:0] jt;
   } err_type;

endpackage

`default_nettype wire

// File: rtl/oeg_prod_stage.sv
// ----------------------------------------------------------------------------
// oeg_prod_stage
// First stage: all quaternion pair products and quaternion-reference products.
// ----------------------------------------------------------------------------
`default_nettype none

module oeg_prod_stage (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             up_valid,
   input  wire oeg_pkg::req_type up_data,
   output logic                  dn_valid,
   output oeg_pkg::prod_type     dn_data
);

   localparam int QP_W = oeg_pkg::QP_W;
   localparam int IN_W = oeg_pkg::IN_W;

   logic signed [QP_W-1:0] q_e [4];
   logic signed [QP_W-1:0] r_e [3];

   oeg_pkg::prod_type prod_in;
   oeg_pkg::prod_type prod_ff;
   logic              valid_ff;

   // widen the operands so every product is exact at product width
   always_comb begin
      q_e[0] = {{(QP_W-IN_W){up_data.quat_w[IN_W-1]}}, up_data.quat_w};
      q_e[1] = {{(QP_W-IN_W){up_data.quat_x[IN_W-1]}}, up_data.quat_x};
      q_e[2] = {{(QP_W-IN_W){up_data.quat_y[IN_W-1]}}, up_data.quat_y};
      q_e[3] = {{(QP_W-IN_W){up_data.quat_z[IN_W-1]}}, up_data.quat_z};
      r_e[0] = {{(QP_W-IN_W){up_data.ref_x[IN_W-1]}}, up_data.ref_x};
      r_e[1] = {{(QP_W-IN_W){up_data.ref_y[IN_W-1]}}, up_data.ref_y};
      r_e[2] = {{(QP_W-IN_W){up_data.ref_z[IN_W-1]}}, up_data.ref_z};
   end

   // form the products
   always_comb begin
      prod_in.xx = q_e[1] * q_e[1];
      prod_in.yy = q_e[2] * q_e[2];
      prod_in.zz = q_e[3] * q_e[3];
      prod_in.xy = q_e[1] * q_e[2];
      prod_in.xz = q_e[1] * q_e[3];
      prod_in.yz = q_e[2] * q_e[3];
      prod_in.wx = q_e[0] * q_e[1];
      prod_in.wy = q_e[0] * q_e[2];
      prod_in.wz = q_e[0] * q_e[3];
      for (int i = 0; i < 4; i++) begin
         for (int k = 0; k < 3; k++) begin
            prod_in.qr[i][k] = q_e[i] * r_e[k];
         end
      end
      prod_in.r = {up_data.ref_z, up_data.ref_y, up_data.ref_x};
      prod_in.m = {up_data.meas_z, up_data.meas_y, up_data.meas_x};
   end

   // advance the valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= up_valid;
      end
   end

   // hold the payload
   always_ff @(posedge clock) begin
      if (up_valid) begin
         prod_ff <= prod_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = prod_ff;

endmodule

`default_nettype wire

// File: rtl/oeg_coef_stage.sv
// ----------------------------------------------------------------------------
// oeg_coef_stage
// Second stage: objective coefficients and transposed Jacobian entries.
// ----------------------------------------------------------------------------
`default_nettype none

module oeg_coef_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              up_valid,
   input  wire oeg_pkg::prod_type up_data,
   output logic                   dn_valid,
   output oeg_pkg::coef_type      dn_data
);

   localparam int QP_W = oeg_pkg::QP_W;
   localparam int FC_W = oeg_pkg::FC_W;
   localparam int JT_W = oeg_pkg::JT_W;
   localparam logic signed [JT_W-1:0] ONE = oeg_pkg::ONE_Q28;

   logic signed [JT_W-1:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
   logic signed [JT_W-1:0] qr [4][3];
   logic signed [JT_W-1:0] fc [3][3];

   oeg_pkg::coef_type coef_in;
   oeg_pkg::coef_type coef_ff;
   logic              valid_ff;

   // widen the products
   always_comb begin
      xx = {{(JT_W-QP_W){up_data.xx[QP_W-1]}}, up_data.xx};
      yy = {{(JT_W-QP_W){up_data.yy[QP_W-1]}}, up_data.yy};
      zz = {{(JT_W-QP_W){up_data.zz[QP_W-1]}}, up_data.zz};
      xy = {{(JT_W-QP_W){up_data.xy[QP_W-1]}}, up_data.xy};
      xz = {{(JT_W-QP_W){up_data.xz[QP_W-1]}}, up_data.xz};
      yz = {{(JT_W-QP_W){up_data.yz[QP_W-1]}}, up_data.yz};
      wx = {{(JT_W-QP_W){up_data.wx[QP_W-1]}}, up_data.wx};
      wy = {{(JT_W-QP_W){up_data.wy[QP_W-1]}}, up_data.wy};
      wz = {{(JT_W-QP_W){up_data.wz[QP_W-1]}}, up_data.wz};
      for (int i = 0; i < 4; i++) begin
         for (int k = 0; k < 3; k++) begin
            qr[i][k] = {{(JT_W-QP_W){up_data.qr[i][k][QP_W-1]}}, up_data.qr[i][k]};
         end
      end
   end

   // rotation matrix of the conjugate quaternion, row j multiplies r
   always_comb begin
      fc[0][0] = ONE - (yy <<< 1) - (zz <<< 1);
      fc[0][1] = (wz + xy) <<< 1;
      fc[0][2] = (xz - wy) <<< 1;
      fc[1][0] = (xy - wz) <<< 1;
      fc[1][1] = ONE - (xx <<< 1) - (zz <<< 1);
      fc[1][2] = (wx + yz) <<< 1;
      fc[2][0] = (wy + xz) <<< 1;
      fc[2][1] = (yz - wx) <<< 1;
      fc[2][2] = ONE - (xx <<< 1) - (yy <<< 1);
   end

   // build the coefficient word; q index w=0 x=1 y=2 z=3, r index x=0 y=1 z=2
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         for (int k = 0; k < 3; k++) begin
            coef_in.fc[j][k] = fc[j][k][FC_W-1:0];
         end
      end
      coef_in.jt[0][0] = (qr[3][1] - qr[2][2]) <<< 1;
      coef_in.jt[0][1] = (qr[1][2] - qr[3][0]) <<< 1;
      coef_in.jt[0][2] = (qr[2][0] - qr[1][1]) <<< 1;
      coef_in.jt[1][0] = (qr[2][1] + qr[3][2]) <<< 1;
      coef_in.jt[1][1] = ((qr[2][0] + qr[0][2]) <<< 1) - (qr[1][1] <<< 2);
      coef_in.jt[1][2] = ((qr[3][0] - qr[0][1]) <<< 1) - (qr[1][2] <<< 2);
      coef_in.jt[2][0] = ((qr[1][1] - qr[0][2]) <<< 1) - (qr[2][0] <<< 2);
      coef_in.jt[2][1] = (qr[3][2] + qr[1][0]) <<< 1;
      coef_in.jt[2][2] = ((qr[3][1] + qr[0][0]) <<< 1) - (qr[2][2] <<< 2);
      coef_in.jt[3][0] = ((qr[1][2] + qr[0][1]) <<< 1) - (qr[3][0] <<< 2);
      coef_in.jt[3][1] = ((qr[2][2] - qr[0][0]) <<< 1) - (qr[3][1] <<< 2);
      coef_in.jt[3][2] = (qr[1][0] + qr[2][1]) <<< 1;
      coef_in.r = up_data.r;
      coef_in.m = up_data.m;
   end

   // advance the valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= up_valid;
      end
   end

   // hold the payload
   always_ff @(posedge clock) begin
      if (up_valid) begin
         coef_ff <= coef_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = coef_ff;

endmodule

`default_nettype wire

// File: rtl/oeg_err_stage.sv
// ----------------------------------------------------------------------------
// oeg_err_stage
// Third and fourth stages: rotate the reference, subtract the measurement and
// round the error vector to Q14.
// ----------------------------------------------------------------------------
`default_nettype none

module oeg_err_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              up_valid,
   input  wire oeg_pkg::coef_type up_data,
   output logic                   dn_valid,
   output oeg_pkg::err_type       dn_data
);

   localparam int IN_W       = oeg_pkg::IN_W;
   localparam int FC_W       = oeg_pkg::FC_W;
   localparam int JT_W       = oeg_pkg::JT_W;
   localparam int FP_W       = oeg_pkg::FP_W;
   localparam int F_W        = oeg_pkg::F_W;
   localparam int FRAC_SHIFT = oeg_pkg::FRAC_SHIFT;
   localparam logic signed [F_W-1:0] F_BIAS = F_W'(1) << (FRAC_SHIFT - 1);

   // stage 3 signals
   logic signed [FP_W-1:0]    fc_e [3][3];
   logic signed [FP_W-1:0]    r_e [3];
   logic [2:0][2:0][FP_W-1:0] fp_in;
   logic [2:0][2:0][FP_W-1:0] fp_ff;
   logic [3:0][2:0][JT_W-1:0] jt_ff;
   oeg_pkg::vec3_type         m_ff;
   logic                      fp_valid_ff;

   // stage 4 signals
   logic signed [F_W-1:0] f_sum [3];
   oeg_pkg::err_type      err_in;
   oeg_pkg::err_type      err_ff;
   logic                  err_valid_ff;

   // multiply each coefficient by its reference component
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         r_e[k] = {{(FP_W-IN_W){up_data.r[k][IN_W-1]}}, up_data.r[k]};
      end
      for (int j = 0; j < 3; j++) begin
         for (int k = 0; k < 3; k++) begin
            fc_e[j][k] = {{(FP_W-FC_W){up_data.fc[j][k][FC_W-1]}}, up_data.fc[j][k]};
            fp_in[j][k] = fc_e[j][k] * r_e[k];
         end
      end
   end

   // sum the row, subtract the measurement, round half up to Q14
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         f_sum[j] = {{(F_W-FP_W){fp_ff[j][0][FP_W-1]}}, fp_ff[j][0]}
                  + {{(F_W-FP_W){fp_ff[j][1][FP_W-1]}}, fp_ff[j][1]}
                  + {{(F_W-FP_W){fp_ff[j][2][FP_W-1]}}, fp_ff[j][2]}
                  - ({{(F_W-IN_W){m_ff[j][IN_W-1]}}, m_ff[j]} <<< FRAC_SHIFT)
                  + F_BIAS;
         err_in.e[j] = f_sum[j][F_W-1:FRAC_SHIFT];
      end
      err_in.jt = jt_ff;
   end

   // advance the valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         fp_valid_ff  <= 1'b0;
         err_valid_ff <= 1'b0;
      end else begin
         fp_valid_ff  <= up_valid;
         err_valid_ff <= fp_valid_ff;
      end
   end

   // hold the payload of stage 3
   always_ff @(posedge clock) begin
      if (up_valid) begin
         fp_ff <= fp_in;
         jt_ff <= up_data.jt;
         m_ff  <= up_data.m;
      end
   end

   // hold the payload of stage 4
   always_ff @(posedge clock) begin
      if (fp_valid_ff) begin
         err_ff <= err_in;
      end
   end

   assign dn_valid = err_valid_ff;
   assign dn_data  = err_ff;

endmodule

`default_nettype wire

// File: rtl/oeg_grad_stage.sv
// ----------------------------------------------------------------------------
// oeg_grad_stage
// Fifth and sixth stages: multiply the error by the transposed Jacobian, round
// and saturate the gradient.
// ----------------------------------------------------------------------------
`default_nettype none

module oeg_grad_stage (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             up_valid,
   input  wire oeg_pkg::err_type up_data,
   output logic                  dn_valid,
   output oeg_pkg::rsp_type      dn_data
);

   localparam int JT_W       = oeg_pkg::JT_W;
   localparam int E_W        = oeg_pkg::E_W;
   localparam int GP_W       = oeg_pkg::GP_W;
   localparam int ACC_W      = oeg_pkg::ACC_W;
   localparam int RND_W      = oeg_pkg::RND_W;
   localparam int OUT_W      = oeg_pkg::OUT_W;
   localparam int FRAC_SHIFT = oeg_pkg::FRAC_SHIFT;
   localparam logic signed [ACC_W-1:0] ACC_BIAS = ACC_W'(1) << (FRAC_SHIFT - 1);
   localparam logic signed [RND_W-1:0] SAT_HI   = (RND_W'(1) << (OUT_W - 1)) - RND_W'(1);
   localparam logic signed [RND_W-1:0] SAT_LO   = -SAT_HI - RND_W'(1);

   // stage 5 signals
   logic signed [GP_W-1:0]    jt_e [4][3];
   logic signed [GP_W-1:0]    e_e [3];
   logic [3:0][2:0][GP_W-1:0] gp_in;
   logic [3:0][2:0][GP_W-1:0] gp_ff;
   logic                      gp_valid_ff;

   // stage 6 signals
   logic signed [ACC_W-1:0]   acc [4];
   logic signed [RND_W-1:0]   rnd [4];
   logic [3:0][OUT_W-1:0]     sat;
   oeg_pkg::rsp_type          rsp_in;
   oeg_pkg::rsp_type          rsp_ff;
   logic                      rsp_valid_ff;

   // multiply each Jacobian entry by its error component
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         e_e[j] = {{(GP_W-E_W){up_data.e[j][E_W-1]}}, up_data.e[j]};
      end
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 3; j++) begin
            jt_e[i][j] = {{(GP_W-JT_W){up_data.jt[i][j][JT_W-1]}}, up_data.jt[i][j]};
            gp_in[i][j] = jt_e[i][j] * e_e[j];
         end
      end
   end

   // sum, round half up to Q14 and clamp to the output range
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         acc[i] = {{(ACC_W-GP_W){gp_ff[i][0][GP_W-1]}}, gp_ff[i][0]}
                + {{(ACC_W-GP_W){gp_ff[i][1][GP_W-1]}}, gp_ff[i][1]}
                + {{(ACC_W-GP_W){gp_ff[i][2][GP_W-1]}}, gp_ff[i][2]}
                + ACC_BIAS;
         rnd[i] = acc[i][ACC_W-1:FRAC_SHIFT];
         if (rnd[i] > SAT_HI) begin
            sat[i] = SAT_HI[OUT_W-1:0];
         end else if (rnd[i] < SAT_LO) begin
            sat[i] = SAT_LO[OUT_W-1:0];
         end else begin
            sat[i] = rnd[i][OUT_W-1:0];
         end
      end
      rsp_in.grad_w = sat[0];
      rsp_in.grad_x = sat[1];
      rsp_in.grad_y = sat[2];
      rsp_in.grad_z = sat[3];
   end

   // advance the valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         gp_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         gp_valid_ff  <= up_valid;
         rsp_valid_ff <= gp_valid_ff;
      end
   end

   // hold the payload of stage 5
   always_ff @(posedge clock) begin
      if (up_valid) begin
         gp_ff <= gp_in;
      end
   end

   // hold the result word
   always_ff @(posedge clock) begin
      if (gp_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign dn_valid = rsp_valid_ff;
   assign dn_data  = rsp_ff;

endmodule

`default_nettype wire

// File: rtl/orientation_error_gradient.sv
// ----------------------------------------------------------------------------
// orientation_error_gradient
// Gradient of the orientation objective: rotate the reference by the conjugate
// quaternion, subtract the measurement, multiply by the transposed Jacobian.
//
//   channel  | ports                          | handshake
//   ---------+--------------------------------+--------------------------------
//   request  | start, busy, req_data          | taken when start && !busy
//   response | rsp_valid, rsp_data            | one-cycle strobe, no back-pressure
//
// One request word per cycle outside reset. Each word passes through the six
// register stages: products, coefficients, reference rotation, error rounding,
// Jacobian multiply, sum and saturation.
// busy is high only during reset; the pipeline never stalls.
// Reset clears the valid bits; nothing is in flight after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module orientation_error_gradient (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire oeg_pkg::req_type req_data,
   output logic                  rsp_valid,
   output oeg_pkg::rsp_type      rsp_data
);

   logic              accept;
   logic              prod_valid;
   oeg_pkg::prod_type prod_data;
   logic              coef_valid;
   oeg_pkg::coef_type coef_data;
   logic              err_valid;
   oeg_pkg::err_type  err_data;

   // take a word in every cycle outside reset
   assign busy   = reset;
   assign accept = start & ~busy;

   oeg_prod_stage u_prod (
      .clock    (clock),
      .reset    (reset),
      .up_valid (accept),
      .up_data  (req_data),
      .dn_valid (prod_valid),
      .dn_data  (prod_data)
   );

   oeg_coef_stage u_coef (
      .clock    (clock),
      .reset    (reset),
      .up_valid (prod_valid),
      .up_data  (prod_data),
      .dn_valid (coef_valid),
      .dn_data  (coef_data)
   );

   oeg_err_stage u_err (
      .clock    (clock),
      .reset    (reset),
      .up_valid (coef_valid),
      .up_data  (coef_data),
      .dn_valid (err_valid),
      .dn_data  (err_data)
   );

   oeg_grad_stage u_grad (
      .clock    (clock),
      .reset    (reset),
      .up_valid (err_valid),
      .up_data  (err_data),
      .dn_valid (rsp_valid),
      .dn_data  (rsp_data)
   );

endmodule

`default_nettype wire

// File: rtl/oeg_checker.sv
// ----------------------------------------------------------------------------
// oeg_checker
// Port-level checks of the orientation error gradient, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module oeg_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire oeg_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire oeg_pkg::rsp_type rsp_data
);

   localparam int LATENCY = oeg_pkg::LATENCY;

   // no back-pressure outside reset
   a_never_busy : assert property (@(posedge clock) disable iff (reset)
      !busy)
      else $error("busy raised outside reset");

   // every accepted word produces a result after the pipeline latency
   a_word_to_result : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("accepted word produced no result");

   // no result without an accepted word at the matching cycle
   a_result_from_word : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result strobe without a request");

   // a zero quaternion or a zero reference gives a zero Jacobian
   a_zero_gradient : assert property (@(posedge clock) disable iff (reset)
      (start && !busy &&
       ((req_data.quat_w == '0 && req_data.quat_x == '0 &&
         req_data.quat_y == '0 && req_data.quat_z == '0) ||
        (req_data.ref_x == '0 && req_data.ref_y == '0 && req_data.ref_z == '0)))
      |-> ##LATENCY (rsp_data == '0))
      else $error("nonzero gradient from a zero Jacobian");

endmodule

bind orientation_error_gradient oeg_checker u_oeg_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

`default_nettype wire
